// ----- rtl/hcls_pkg.sv -----
// Shared types, constants and the mod-26 reduction for the Hill cipher letter stream.
// No dependencies; every other file of the block uses this package.
package hcls_pkg;

  localparam int unsigned MaxDim = 3;
  localparam int unsigned LetW   = 5;
  localparam int unsigned RowW   = MaxDim * LetW;
  localparam int unsigned SumW   = 12;

  localparam logic [6:0] CharBase = 7'd65;  // 'A'
  localparam logic [4:0] PadLet   = 5'd23;  // 'X'
  localparam logic [4:0] Modulus  = 5'd26;

  typedef enum logic [2:0] {
    REG_BLOCK_SIZE = 3'd0,
    REG_DIRECTION  = 3'd1,
    REG_FWD_ROW0   = 3'd2,
    REG_FWD_ROW1   = 3'd3,
    REG_FWD_ROW2   = 3'd4,
    REG_INV_ROW0   = 3'd5,
    REG_INV_ROW1   = 3'd6,
    REG_INV_ROW2   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]                     block_size;
    logic                           direction;
    logic [MaxDim-1:0][RowW-1:0]    fwd_row;
    logic [MaxDim-1:0][RowW-1:0]    inv_row;
  } cfg_t;

  // One finished block headed for the output serializer.
  typedef struct packed {
    logic [MaxDim-1:0][LetW-1:0] letters;
    logic [1:0]                  cnt;
    logic                        last;
  } blk_t;

  // x mod 26 for x <= 2325. q = x*315 >> 13 is floor(x/26) or one less,
  // so a single conditional subtract finishes it.
  function automatic logic [LetW-1:0] mod26(input logic [SumW-1:0] x);
    logic [20:0]     prod;
    logic [7:0]      q;
    logic [SumW-1:0] qm;
    logic [SumW-1:0] r;
    prod = 21'(x) * 21'd315;
    q    = prod[20:13];
    qm   = SumW'(q) * SumW'(Modulus);
    r    = x - qm;
    if (r >= SumW'(Modulus)) begin
      r = r - SumW'(Modulus);
    end
    return r[LetW-1:0];
  endfunction

endpackage

// ----- rtl/hcls_if.sv -----
// Valid/ready channel interfaces: character input, letter output, register writes.
// Depends on hcls_pkg for field widths.
interface hcls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_message;

  modport source (output valid, output char_in, output end_of_message, input ready);
  modport sink   (input valid, input char_in, input end_of_message, output ready);
endinterface

interface hcls_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_out;
  logic       last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface

interface hcls_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   index;
  logic [hcls_pkg::RowW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/hcls_cfg.sv -----
// Configuration register file: block size, direction and both key matrices.
// Depends on hcls_pkg and hcls_cfg_if.
module hcls_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  hcls_cfg_if.sink        cfg_i,
  output hcls_pkg::cfg_t  cfg_o
);
  import hcls_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{block_size: 2'd2, direction: 1'b0, fwd_row: '0, inv_row: '0};
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BLOCK_SIZE: cfg_q.block_size <= cfg_i.data[1:0];
        REG_DIRECTION:  cfg_q.direction  <= cfg_i.data[0];
        REG_FWD_ROW0:   cfg_q.fwd_row[0] <= cfg_i.data;
        REG_FWD_ROW1:   cfg_q.fwd_row[1] <= cfg_i.data;
        REG_FWD_ROW2:   cfg_q.fwd_row[2] <= cfg_i.data;
        REG_INV_ROW0:   cfg_q.inv_row[0] <= cfg_i.data;
        REG_INV_ROW1:   cfg_q.inv_row[1] <= cfg_i.data;
        REG_INV_ROW2:   cfg_q.inv_row[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/hcls_proc.sv -----
// Input register, letter buffer and the mod-26 matrix product for one block.
// Depends on hcls_pkg and hcls_in_if.
module hcls_proc (
  input  logic            clk_i,
  input  logic            rst_ni,
  hcls_in_if.sink         char_i,
  input  hcls_pkg::cfg_t  cfg_i,
  input  logic            can_load_i,
  output logic            blk_valid_o,
  output hcls_pkg::blk_t  blk_o
);
  import hcls_pkg::*;

  // input decode
  logic            in_letter;
  logic [LetW-1:0] in_val;

  // input register
  logic            s1_valid_q;
  logic            s1_letter_q;
  logic [LetW-1:0] s1_val_q;
  logic            s1_eom_q;
  logic            s1_adv;

  // block state
  logic [MaxDim-1:0][LetW-1:0] buf_q, buf_d;
  logic [1:0]                  fill_q, fill_d;

  logic                        bs3;
  logic [1:0]                  bs;
  logic [1:0]                  idx;
  logic [1:0]                  fill_n;
  logic                        full, flush, emit;
  logic [MaxDim-1:0][LetW-1:0] blk_in;
  logic [MaxDim-1:0][RowW-1:0] rows;
  logic [MaxDim-1:0][LetW-1:0] res;

  always_comb begin
    in_letter = 1'b0;
    in_val    = '0;
    if (char_i.char_in inside {[8'd65:8'd90]}) begin
      in_letter = 1'b1;
      in_val    = LetW'(char_i.char_in - 8'd65);
    end else if (char_i.char_in inside {[8'd97:8'd122]}) begin
      in_letter = 1'b1;
      in_val    = LetW'(char_i.char_in - 8'd97);
    end
  end

  assign char_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      s1_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      s1_letter_q <= in_letter;
      s1_val_q    <= in_val;
      s1_eom_q    <= char_i.end_of_message;
    end
  end

  always_comb begin
    bs3    = (cfg_i.block_size == 2'd3);
    bs     = bs3 ? 2'd3 : 2'd2;
    // write index saturates at the last slot if the block size shrank
    idx    = (fill_q < bs) ? fill_q : bs - 2'd1;
    buf_d  = buf_q;
    fill_n = fill_q;
    if (s1_letter_q) begin
      buf_d[idx] = s1_val_q;
      fill_n     = idx + 2'd1;
    end
    full  = s1_letter_q && (fill_n == bs);
    flush = !full && s1_eom_q && (fill_n != 2'd0);
    emit  = full || flush;

    blk_in = buf_d;
    for (int i = 0; i < MaxDim; i++) begin
      if (flush && (2'(i) >= fill_n)) begin
        blk_in[i] = PadLet;
      end
    end
  end

  assign rows = cfg_i.direction ? cfg_i.inv_row : cfg_i.fwd_row;

  always_comb begin
    logic [SumW-1:0] sum;
    logic [LetW-1:0] k;
    for (int r = 0; r < MaxDim; r++) begin
      sum = '0;
      for (int c = 0; c < MaxDim; c++) begin
        k = rows[r][c*LetW +: LetW];
        if (c < 2 || bs3) begin
          sum = sum + SumW'(k) * SumW'(blk_in[c]);
        end
      end
      res[r] = mod26(sum);
    end
  end

  // a block-producing item waits until the serializer can take the block
  assign s1_adv      = s1_valid_q && (!emit || can_load_i);
  assign blk_valid_o = s1_adv && emit;

  always_comb begin
    blk_o.letters = res;
    blk_o.cnt     = bs;
    blk_o.last    = s1_eom_q;
  end

  assign fill_d = emit ? 2'd0 : fill_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else if (s1_adv) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      buf_q <= buf_d;
    end
  end

endmodule

// ----- rtl/hcls_ser.sv -----
// Result register holding one finished block and sending it out a letter per request.
// Depends on hcls_pkg and hcls_out_if.
module hcls_ser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            blk_valid_i,
  input  hcls_pkg::blk_t  blk_i,
  output logic            can_load_o,
  hcls_out_if.source      char_o
);
  import hcls_pkg::*;

  logic                        res_valid_q;
  logic [MaxDim-1:0][LetW-1:0] letters_q;
  logic [1:0]                  cnt_q;
  logic [1:0]                  idx_q;
  logic                        last_q;
  logic                        on_final;
  logic                        pop;

  assign on_final   = (idx_q == cnt_q - 2'd1);
  assign pop        = res_valid_q && char_o.ready;
  assign can_load_o = !res_valid_q || (pop && on_final);

  assign char_o.valid    = res_valid_q;
  assign char_o.char_out = CharBase + 7'(letters_q[idx_q]);
  assign char_o.last     = last_q && on_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (blk_valid_i) begin
      res_valid_q <= 1'b1;
      idx_q       <= 2'd0;
    end else if (pop) begin
      if (on_final) begin
        res_valid_q <= 1'b0;
        idx_q       <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_valid_i) begin
      letters_q <= blk_i.letters;
      cnt_q     <= blk_i.cnt;
      last_q    <= blk_i.last;
    end
  end

endmodule

// ----- rtl/hill_cipher_letter_stream_core.sv -----
// Top level of the Hill cipher letter stream (mod 26, blocks of 2 or 3 letters).
// Depends on hcls_pkg, hcls_if, hcls_cfg, hcls_proc and hcls_ser.
//
// Usage:
//   char_i  carries one ASCII byte per request plus end_of_message. Non-letters
//           are dropped, lower case folds to upper case.
//   char_o  sends one upper-case letter per request; last marks the final
//           letter of a block completed or flushed by an end-of-message byte.
//   cfg_i   writes registers 0..7 (block_size, direction, fwd/inv rows); always
//           ready. The user must write only while the block is idle, unchecked.
// Path: a byte that completes a block moves from the input register into the
//   result register, which drives its first letter onto char_o.
// Throughput: one byte per cycle while no block waits. A finished block
//   occupies the result register until its final letter is taken; a
//   further block-completing byte waits in the input register until then
//   and holds back the bytes behind it.
// Reset: fill count clears, block size returns to 2, direction and key rows to 0.
// A stalled char_o holds its letter; backpressure reaches char_i only through
//   the single input register.
module hill_cipher_letter_stream_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcls_in_if.sink     char_i,
  hcls_out_if.source  char_o,
  hcls_cfg_if.sink    cfg_i
);
  import hcls_pkg::*;

  cfg_t cfg;
  blk_t blk;
  logic blk_valid;
  logic can_load;

  hcls_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  hcls_proc u_proc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_i),
    .cfg_i       (cfg),
    .can_load_i  (can_load),
    .blk_valid_o (blk_valid),
    .blk_o       (blk)
  );

  hcls_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (blk_valid),
    .blk_i       (blk),
    .can_load_o  (can_load),
    .char_o      (char_o)
  );

  // a new block never overwrites one still being sent
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid |-> can_load)
    else $error("block loaded while result register busy");

  a_blk_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid |-> (blk.cnt == 2'd2 || blk.cnt == 2'd3))
    else $error("block with bad letter count");

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_o.valid |-> (char_o.char_out >= 7'd65 && char_o.char_out <= 7'd90))
    else $error("output letter out of range");

  // after the last letter of a message leaves, no further letter is pending
  // unless a new block was loaded in that same cycle
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_o.valid && char_o.ready && char_o.last && !blk_valid) |=> !char_o.valid)
    else $error("result register not drained after last letter");

endmodule

// ----- test/hcls_letter_checker.sv -----
// Letter checker: watches the character, letter and register channels, predicts
// the cipher letters from the accepted requests and compares them in order.
// Depends on hcls_pkg and the channel interfaces of hcls_if.
module hcls_letter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcls_in_if          char_mon,
  hcls_out_if         letter_mon,
  hcls_cfg_if         reg_mon,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import hcls_pkg::*;

  typedef struct packed {
    logic [6:0] char_out;
    logic       last;
  } letter_t;

  logic [1:0]      cfg_block_size;
  logic            cfg_direction;
  logic [RowW-1:0] cfg_fwd [MaxDim];
  logic [RowW-1:0] cfg_inv [MaxDim];

  logic [LetW-1:0] held [MaxDim];
  int unsigned     held_cnt;

  letter_t     letters_due [$];
  int unsigned fail_cnt = 0;
  int unsigned due_cnt  = 0;

  assign errors_o  = fail_cnt;
  assign pending_o = due_cnt;

  // Multiply the held block by the selected matrix and queue the letters.
  task automatic encipher_block(input int unsigned dim, input logic eom);
    logic [RowW-1:0] row;
    int unsigned     sum;
    letter_t         res;
    for (int r = 0; r < dim; r++) begin
      row = cfg_direction ? cfg_inv[r] : cfg_fwd[r];
      sum = 0;
      for (int c = 0; c < dim; c++) begin
        sum += 32'(row[LetW*c +: LetW]) * 32'(held[c]);
      end
      res.char_out = 7'(sum % Modulus) + CharBase;
      res.last     = eom && (r == dim - 1);
      letters_due.push_back(res);
    end
    held_cnt = 0;
  endtask

  task automatic take_char(input logic [7:0] code, input logic eom);
    int unsigned     dim;
    int unsigned     slot;
    logic            is_letter;
    logic [LetW-1:0] value;
    dim       = (cfg_block_size == 2'd3) ? 3 : 2;
    is_letter = 1'b1;
    value     = '0;
    if (code inside {[8'd65:8'd90]}) begin
      value = LetW'(code - 8'd65);
    end else if (code inside {[8'd97:8'd122]}) begin
      value = LetW'(code - 8'd97);
    end else begin
      is_letter = 1'b0;
    end
    if (is_letter) begin
      // after a block size shrink the write slot sticks at the last position
      slot       = (held_cnt < dim) ? held_cnt : dim - 1;
      held[slot] = value;
      held_cnt   = slot + 1;
      if (held_cnt == dim) begin
        encipher_block(dim, eom);
        return;
      end
    end
    if (eom && held_cnt != 0) begin
      for (int i = held_cnt; i < dim; i++) begin
        held[i] = PadLet;
      end
      encipher_block(dim, 1'b1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    letter_t want;
    letter_t got;
    if (!rst_ni) begin
      cfg_block_size = 2'd2;
      cfg_direction  = 1'b0;
      for (int i = 0; i < MaxDim; i++) begin
        cfg_fwd[i] = '0;
        cfg_inv[i] = '0;
        held[i]    = '0;
      end
      held_cnt = 0;
      letters_due.delete();
      due_cnt = 0;
    end else begin
      if (letter_mon.valid && letter_mon.ready) begin
        got.char_out = letter_mon.char_out;
        got.last     = letter_mon.last;
        if (letters_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("checker: unexpected letter %c last=%0b", got.char_out, got.last);
          end
        end else begin
          want = letters_due.pop_front();
          if (want != got) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("checker: expected %c last=%0b, got %c last=%0b",
                       want.char_out, want.last, got.char_out, got.last);
            end
          end
        end
      end
      if (reg_mon.valid && reg_mon.ready) begin
        case (cfg_reg_e'(reg_mon.index))
          REG_BLOCK_SIZE: cfg_block_size = reg_mon.data[1:0];
          REG_DIRECTION:  cfg_direction  = reg_mon.data[0];
          REG_FWD_ROW0:   cfg_fwd[0]     = reg_mon.data;
          REG_FWD_ROW1:   cfg_fwd[1]     = reg_mon.data;
          REG_FWD_ROW2:   cfg_fwd[2]     = reg_mon.data;
          REG_INV_ROW0:   cfg_inv[0]     = reg_mon.data;
          REG_INV_ROW1:   cfg_inv[1]     = reg_mon.data;
          REG_INV_ROW2:   cfg_inv[2]     = reg_mon.data;
          default: ;
        endcase
      end
      if (char_mon.valid && char_mon.ready) begin
        take_char(char_mon.char_in, char_mon.end_of_message);
      end
      due_cnt = letters_due.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// Testbench top: drives character requests, register writes and output backpressure
// into hill_cipher_letter_stream_core and gives the verdict.
// Depends on hcls_pkg, hcls_if, the core RTL and hcls_letter_checker.
module tb;
  import hcls_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  logic clk_i;
  logic rst_ni;

  hcls_in_if  char_if ();
  hcls_out_if letter_if ();
  hcls_cfg_if reg_if ();

  int unsigned mismatch_cnt;
  int unsigned letters_pending;
  int unsigned cycle_cnt = 0;
  int unsigned useful_items = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  logic [1:0]      bs_sel;
  logic            dir_sel;
  logic [RowW-1:0] key_rows [6];  // forward rows 0..2, then inverse rows 0..2

  hill_cipher_letter_stream_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .char_o (letter_if),
    .cfg_i  (reg_if)
  );

  hcls_letter_checker u_letter_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_mon   (char_if),
    .letter_mon (letter_if),
    .reg_mon    (reg_if),
    .errors_o   (mismatch_cnt),
    .pending_o  (letters_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    letter_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [RowW-1:0] rand_row();
    logic [RowW-1:0] row;
    if ($urandom_range(1) == 1) begin
      return RowW'($urandom());
    end
    for (int c = 0; c < MaxDim; c++) begin
      row[LetW*c +: LetW] = LetW'($urandom_range(25));
    end
    return row;
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) begin
      return 8'(65 + $urandom_range(25));
    end
    if (roll < 80) begin
      return 8'(97 + $urandom_range(25));
    end
    return 8'($urandom_range(255));
  endfunction

  // Valid stays high from one request to the next unless an idle cycle is drawn.
  task automatic send_char(input logic [7:0] code, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      char_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_if.valid          <= 1'b1;
    char_if.char_in        <= code;
    char_if.end_of_message <= eom;
    do @(posedge clk_i); while (!char_if.ready);
    if (eom || (code inside {[8'd65:8'd90], [8'd97:8'd122]})) begin
      useful_items++;
    end
  endtask

  task automatic send_message(input int unsigned len);
    for (int i = 0; i < len; i++) begin
      send_char(pick_byte(), 1'b0);
    end
    send_char(pick_byte(), 1'b1);
  endtask

  // Wait for every letter to drain, plus slack for a byte that makes no letter.
  task automatic settle();
    char_if.valid <= 1'b0;
    do @(posedge clk_i); while (letters_pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_config();
    settle();
    for (int i = 0; i < 8; i++) begin
      reg_if.valid <= 1'b1;
      reg_if.index <= 3'(i);
      case (cfg_reg_e'(i))
        REG_BLOCK_SIZE: reg_if.data <= RowW'(bs_sel);
        REG_DIRECTION:  reg_if.data <= RowW'(dir_sel);
        default:        reg_if.data <= key_rows[i - 2];
      endcase
      do @(posedge clk_i); while (!reg_if.ready);
    end
    reg_if.valid <= 1'b0;
  endtask

  initial begin
    int unsigned roll;
    int unsigned target;
    rst_ni                 = 1'b0;
    char_if.valid          = 1'b0;
    char_if.char_in        = '0;
    char_if.end_of_message = 1'b0;
    letter_if.ready        = 1'b0;
    reg_if.valid           = 1'b0;
    reg_if.index           = REG_BLOCK_SIZE;
    reg_if.data            = '0;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    bs_sel  = 2'd2;
    dir_sel = 1'b0;
    for (int k = 0; k < 6; k++) begin
      key_rows[k] = rand_row();
    end
    load_config();
    send_char("A", 1'b0);
    send_char("Z", 1'b0);
    send_char("a", 1'b0);
    send_char("z", 1'b0);
    send_char(8'h40, 1'b0);
    send_char(8'h5B, 1'b0);
    send_char(8'h60, 1'b0);
    send_char(8'h7B, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("H", 1'b1);    // lone letter on end request, padded
    send_char(8'h00, 1'b1);  // end with nothing buffered
    send_char("Q", 1'b0);
    send_char("r", 1'b1);    // end letter completes the block
    send_char("m", 1'b0);
    send_char("!", 1'b1);
    // shrink the block with two letters held, then complete with a letter
    bs_sel = 2'd3;
    load_config();
    send_char("c", 1'b0);
    send_char("a", 1'b0);
    bs_sel = 2'd2;
    load_config();
    send_char("K", 1'b0);
    // same shrink, flushed by a bare end request
    bs_sel = 2'd3;
    load_config();
    send_char("b", 1'b0);
    send_char("y", 1'b0);
    bs_sel = 2'd2;
    load_config();
    send_char(".", 1'b1);
    send_char("T", 1'b1);

    // random part
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      bs_sel  = 2'(phase);
      dir_sel = (phase >= 4);
      for (int k = 0; k < 6; k++) begin
        key_rows[k] = (phase == 3) ? {RowW{1'b1}} : (phase == 6) ? '0 : rand_row();
      end
      load_config();
      target = useful_items + 13;
      while (useful_items < target) begin
        roll = $urandom_range(99);
        if (roll < 75) begin
          send_message($urandom_range(1, 9));
        end else if (roll < 95) begin
          send_char(8'($urandom_range(255)), $urandom_range(9) == 0);
        end else begin
          // hold off until the output side has caught up
          char_if.valid <= 1'b0;
          do @(posedge clk_i); while (letters_pending != 0);
        end
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
